// ----- rtl/core/lwf_pkg.sv -----
`default_nettype none
package lwf_pkg;

  localparam int unsigned MaxWindowSamples = 4096;
  localparam int unsigned CntW = $clog2(MaxWindowSamples + 1);
  localparam int signed   WindowHalfCdeg = 100;
  localparam int signed   LookaheadMm = 300;
  localparam int signed   Sqrt3Q12 = 7094;
  localparam int signed   RightCdeg = -9000;
  localparam int signed   FrontRightCdeg = -3000;
  localparam int signed   SlowTurnMrad = 1000;

  localparam logic [2:0] CFG_ANGLE_START = 3'd0;
  localparam logic [2:0] CFG_ANGLE_STEP  = 3'd1;
  localparam logic [2:0] CFG_TARGET      = 3'd2;
  localparam logic [2:0] CFG_FRONT_STOP  = 3'd3;
  localparam logic [2:0] CFG_KP          = 3'd4;
  localparam logic [2:0] CFG_KI          = 3'd5;
  localparam logic [2:0] CFG_KD          = 3'd6;
  localparam logic [2:0] CFG_TURN_LIMIT  = 3'd7;

  localparam logic [4:0] SPEED_NORMAL = 5'd30;
  localparam logic [4:0] SPEED_SLOW   = 5'd20;
  localparam logic [4:0] SPEED_AVOID  = 5'd10;

  // controller -> datapath
  typedef struct packed {
    logic beam;       // absorb one beam into the windows
    logic tick_a;     // error, integral
    logic tick_b;     // products
    logic tick_c;     // sum, round, clamp, load result
    logic div_start;  // start a division
    logic div_step;   // one restoring-division bit
    logic sqrt_step;  // one square-root digit
    logic prep_sqrt;  // load sqrt operand from averages
    logic prep_num;   // form numerator
    logic ld_avg_r;   // quotient -> r
    logic ld_avg_r1;  // quotient -> r1
    logic ld_dist;    // quotient -> lookahead
    logic sel_num;    // divider: 0 right window, 1 front-right; sel_dist selects distance
    logic sel_dist;
    logic scan_clear; // clear sums and reload angle
  } lwf_cmd_t;

  typedef struct packed {
    logic windows_ok;
    logic norm_zero;
  } lwf_sts_t;

endpackage
`default_nettype wire

// ----- rtl/core/lwf_ctrl.sv -----
`default_nettype none
module lwf_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic            in_command,
  input  wire logic            in_last_beam,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output lwf_pkg::lwf_cmd_t    cmd,
  input  wire lwf_pkg::lwf_sts_t sts
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DIVR  = 10'b0000000010,
    S_DIVR1 = 10'b0000000100,
    S_SQRT  = 10'b0000001000,
    S_NUM   = 10'b0000010000,
    S_DIVD  = 10'b0000100000,
    S_TA    = 10'b0001000000,
    S_TB    = 10'b0010000000,
    S_TC    = 10'b0100000000,
    S_WAIT  = 10'b1000000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic       ov_r, ov_nxt;
  logic       acc;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ov_r;
  assign acc       = in_valid && in_ready;

  // sequence beats through the datapath
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ov_nxt    = ov_r;
    cmd       = '0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (in_command) begin
            state_nxt = S_TA;
          end else begin
            cmd.beam = 1'b1;
            if (in_last_beam) state_nxt = S_DIVR;
          end
        end
        cnt_nxt = 7'd0;
      end
      S_DIVR: begin
        if (!sts.windows_ok) begin
          cmd.scan_clear = 1'b1;
          state_nxt = S_IDLE;
        end else if (cnt_r == 7'd0) begin
          cmd.div_start = 1'b1;
          cnt_nxt = 7'd1;
        end else if (cnt_r <= 7'd32) begin
          cmd.div_step = 1'b1;
          cnt_nxt = cnt_r + 7'd1;
        end else begin
          cmd.ld_avg_r = 1'b1;
          cnt_nxt = 7'd0;
          state_nxt = S_DIVR1;
        end
      end
      S_DIVR1: begin
        cmd.sel_num = 1'b1;
        if (cnt_r == 7'd0) begin
          cmd.div_start = 1'b1;
          cnt_nxt = 7'd1;
        end else if (cnt_r <= 7'd32) begin
          cmd.div_step = 1'b1;
          cnt_nxt = cnt_r + 7'd1;
        end else begin
          cmd.ld_avg_r1 = 1'b1;
          cnt_nxt = 7'd0;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        if (cnt_r == 7'd0) begin
          cmd.prep_sqrt = 1'b1;
          cnt_nxt = 7'd1;
        end else if (cnt_r <= 7'd32) begin
          cmd.sqrt_step = 1'b1;
          cnt_nxt = cnt_r + 7'd1;
        end else begin
          cnt_nxt = 7'd0;
          state_nxt = S_NUM;
        end
      end
      S_NUM: begin
        if (sts.norm_zero) begin
          cmd.scan_clear = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.prep_num = 1'b1;
          state_nxt = S_DIVD;
        end
      end
      S_DIVD: begin
        cmd.sel_dist = 1'b1;
        if (cnt_r == 7'd0) begin
          cmd.div_start = 1'b1;
          cnt_nxt = 7'd1;
        end else if (cnt_r <= 7'd64) begin
          cmd.div_step = 1'b1;
          cnt_nxt = cnt_r + 7'd1;
        end else begin
          cmd.ld_dist = 1'b1;
          cmd.scan_clear = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_TA: begin
        cmd.tick_a = 1'b1;
        state_nxt = S_TB;
      end
      S_TB: begin
        cmd.tick_b = 1'b1;
        state_nxt = S_TC;
      end
      // hold the last step while the previous result still waits
      S_TC: begin
        if (!ov_r || out_ready) begin
          cmd.tick_c = 1'b1;
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (!ov_r) begin
          ov_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/lwf_dp.sv -----
`default_nettype none
module lwf_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_wdata,
  input  wire logic [15:0]        in_range_mm,
  input  wire lwf_pkg::lwf_cmd_t  cmd,
  output lwf_pkg::lwf_sts_t       sts,
  output logic [4:0]              out_linear_speed_mm_s,
  output logic signed [12:0]      out_turn_rate_mrad_s,
  output logic                    out_obstacle_ahead,
  output logic signed [17:0]      out_wall_distance_mm
);

  localparam int CW = lwf_pkg::CntW;

  // configuration
  logic signed [15:0] start_r;
  logic [11:0] step_r, lim_r;
  logic [15:0] target_r, stop_r, kp_r, ki_r, kd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r  <= -16'sd18000;
      step_r   <= 12'd100;
      target_r <= 16'd300;
      stop_r   <= 16'd2000;
      kp_r     <= 16'd154;
      ki_r     <= 16'd0;
      kd_r     <= 16'd5120;
      lim_r    <= 12'd1820;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lwf_pkg::CFG_ANGLE_START: start_r  <= cfg_wdata;
        lwf_pkg::CFG_ANGLE_STEP:  step_r   <= cfg_wdata[11:0];
        lwf_pkg::CFG_TARGET:      target_r <= cfg_wdata;
        lwf_pkg::CFG_FRONT_STOP:  stop_r   <= cfg_wdata;
        lwf_pkg::CFG_KP:          kp_r     <= cfg_wdata;
        lwf_pkg::CFG_KI:          ki_r     <= cfg_wdata;
        lwf_pkg::CFG_KD:          kd_r     <= cfg_wdata;
        lwf_pkg::CFG_TURN_LIMIT:  lim_r    <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  // beam windows
  logic signed [31:0] ang_r;
  logic [31:0] rsum_r, fsum_r;
  logic [CW-1:0] rcnt_r, fcnt_r;
  logic [15:0] front_r;
  logic in_f, in_r, in_fr, rz;

  assign rz    = (in_range_mm != 16'd0);
  assign in_f  = (ang_r > 32'(-lwf_pkg::WindowHalfCdeg)) &&
                 (ang_r < 32'(lwf_pkg::WindowHalfCdeg));
  assign in_r  = (ang_r > 32'(lwf_pkg::RightCdeg - lwf_pkg::WindowHalfCdeg)) &&
                 (ang_r < 32'(lwf_pkg::RightCdeg + lwf_pkg::WindowHalfCdeg));
  assign in_fr = (ang_r > 32'(lwf_pkg::FrontRightCdeg - lwf_pkg::WindowHalfCdeg)) &&
                 (ang_r < 32'(lwf_pkg::FrontRightCdeg + lwf_pkg::WindowHalfCdeg));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_r   <= 32'(-18000);
      rsum_r  <= '0;
      fsum_r  <= '0;
      rcnt_r  <= '0;
      fcnt_r  <= '0;
      front_r <= 16'hFFFF;
    end else if (cfg_we && cfg_index == lwf_pkg::CFG_ANGLE_START) begin
      ang_r <= {{16{cfg_wdata[15]}}, cfg_wdata};
    end else if (cmd.scan_clear) begin
      ang_r  <= {{16{start_r[15]}}, start_r};
      rsum_r <= '0;
      fsum_r <= '0;
      rcnt_r <= '0;
      fcnt_r <= '0;
    end else if (cmd.beam) begin
      if (in_f) front_r <= rz ? in_range_mm : 16'hFFFF;
      if (in_r && rz && rcnt_r < CW'(lwf_pkg::MaxWindowSamples)) begin
        rsum_r <= rsum_r + {16'd0, in_range_mm};
        rcnt_r <= rcnt_r + 1'b1;
      end
      if (in_fr && rz && fcnt_r < CW'(lwf_pkg::MaxWindowSamples)) begin
        fsum_r <= fsum_r + {16'd0, in_range_mm};
        fcnt_r <= fcnt_r + 1'b1;
      end
      ang_r <= ang_r + {20'd0, step_r};
    end
  end

  assign sts.windows_ok = (rcnt_r != '0) && (fcnt_r != '0);

  // shared restoring divider, 64-bit dividend, magnitude only
  logic [63:0] dq_r;    // dividend shifting into quotient
  logic [64:0] rem_r;
  logic [63:0] den_r;
  logic [64:0] trial;
  logic [31:0] avg_r;
  logic [63:0] num_mag_r;
  logic        num_neg_r;
  logic [31:0] norm_r;

  assign trial = {rem_r[63:0], dq_r[63]} - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r <= '0;
      if (cmd.sel_dist) begin
        // (mag + norm/2) / norm, processed as 64 bits
        dq_r  <= num_mag_r + {33'd0, norm_r[31:1]};
        den_r <= {32'd0, norm_r};
      end else if (cmd.sel_num) begin
        // 32 bits: place at top
        dq_r  <= {fsum_r + {{(33-CW){1'b0}}, fcnt_r[CW-1:1]}, 32'd0};
        den_r <= {{(64-CW){1'b0}}, fcnt_r};
      end else begin
        dq_r  <= {rsum_r + {{(33-CW){1'b0}}, rcnt_r[CW-1:1]}, 32'd0};
        den_r <= {{(64-CW){1'b0}}, rcnt_r};
      end
    end else if (cmd.div_step) begin
      if (!trial[64]) begin
        rem_r <= trial;
        dq_r  <= {dq_r[62:0], 1'b1};
      end else begin
        rem_r <= {rem_r[63:0], dq_r[63]};
        dq_r  <= {dq_r[62:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_avg_r) avg_r <= dq_r[31:0];
  end

  // wall vectoring: x = r1*sqrt3*4096, y = (r1-2r)*4096 (averages fit 16 bits)
  // register both when the front-right average comes out of the divider
  logic signed [17:0] dy;
  logic signed [31:0] x_r, y_r;
  assign dy = $signed({2'b0, dq_r[15:0]}) - $signed({1'b0, avg_r[15:0], 1'b0});

  always_ff @(posedge clk) begin
    if (cmd.ld_avg_r1) begin
      x_r <= $signed({16'd0, dq_r[15:0]}) * 32'(lwf_pkg::Sqrt3Q12);
      y_r <= 32'(dy) <<< 12;
    end
  end

  // digit-by-digit square root of x*x + y*y
  logic [63:0] sq_n_r, sq_res_r, sq_bit_r;
  logic [63:0] sq_sum;
  logic [31:0] ax, ay;
  assign ax = x_r[31] ? 32'(-x_r) : x_r;
  assign ay = y_r[31] ? 32'(-y_r) : y_r;
  assign sq_sum = sq_res_r + sq_bit_r;

  always_ff @(posedge clk) begin
    if (cmd.prep_sqrt) begin
      sq_n_r   <= 64'(ax * ax) + 64'(ay * ay);
      sq_res_r <= '0;
      sq_bit_r <= 64'd1 << 62;
    end else if (cmd.sqrt_step) begin
      if (sq_n_r >= sq_sum) begin
        sq_n_r   <= sq_n_r - sq_sum;
        sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
      end else begin
        sq_res_r <= sq_res_r >> 1;
      end
      sq_bit_r <= sq_bit_r >> 2;
    end
  end
  always_comb norm_r = sq_res_r[31:0];
  assign sts.norm_zero = (sq_res_r == '0);

  // numerator r*x + 300*y
  logic signed [63:0] num_s;
  assign num_s = ($signed({32'd0, avg_r}) * 64'(x_r)) +
                 64'(lwf_pkg::LookaheadMm) * 64'(y_r);
  always_ff @(posedge clk) begin
    if (cmd.prep_num) begin
      num_neg_r <= num_s[63];
      num_mag_r <= num_s[63] ? 64'(-num_s) : num_s;
    end
  end

  // look-ahead distance with saturation
  logic signed [17:0] look_r;
  logic [63:0] qmag;
  assign qmag = dq_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      look_r <= '0;
    end else if (cmd.ld_dist) begin
      if (num_neg_r) look_r <= (qmag > 64'd131072) ? -18'sd131072 : 18'(-qmag);
      else           look_r <= (qmag > 64'd131071) ? 18'sd131071 : 18'(qmag);
    end
  end

  // PID tick
  logic signed [31:0] integ_r;
  logic signed [17:0] perr_r, err_r;
  logic signed [18:0] d_r;
  logic signed [18:0] e_w;
  logic signed [17:0] e_sat;
  logic signed [32:0] i_w;
  logic signed [31:0] i_sat;
  logic signed [35:0] pp_r, pd_r;
  logic signed [48:0] pi_r;
  logic signed [49:0] acc_w, acc_mag;
  logic [41:0] q_w;
  logic signed [12:0] turn_w, lim_s;

  assign e_w   = $signed({3'b0, target_r}) - 19'(look_r);
  assign e_sat = (e_w > 19'sd131071) ? 18'sd131071 :
                 (e_w < -19'sd131072) ? -18'sd131072 : e_w[17:0];
  assign i_w   = 33'(integ_r) + 33'(e_sat);
  assign i_sat = (i_w > 33'sd2147483647) ? 32'sh7FFFFFFF :
                 (i_w < -33'sd2147483648) ? 32'sh80000000 : i_w[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r <= '0;
      perr_r  <= '0;
    end else if (cmd.tick_a) begin
      err_r   <= e_sat;
      d_r     <= 19'(e_sat) - 19'(perr_r);
      perr_r  <= e_sat;
      integ_r <= (target_r == 16'd0 && e_sat == '0) ? 32'sd0 : i_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick_b) begin
      pp_r <= 36'($signed({1'b0, kp_r}) * err_r);
      pi_r <= 49'($signed({1'b0, ki_r}) * integ_r);
      pd_r <= 36'($signed({1'b0, kd_r}) * d_r);
    end
  end

  assign acc_w   = 50'(pp_r) + 50'(pi_r) + 50'(pd_r);
  assign acc_mag = acc_w[49] ? -acc_w : acc_w;
  assign q_w     = 42'((acc_mag + 50'sd128) >>> 8);
  assign lim_s   = $signed({1'b0, lim_r});
  always_comb begin
    if (q_w > {30'd0, lim_r}) turn_w = acc_w[49] ? -lim_s : lim_s;
    else                      turn_w = acc_w[49] ? -13'(q_w) : 13'(q_w);
  end

  always_ff @(posedge clk) begin
    if (cmd.tick_c) begin
      out_wall_distance_mm <= look_r;
      if (front_r <= stop_r) begin
        out_obstacle_ahead    <= 1'b1;
        out_linear_speed_mm_s <= lwf_pkg::SPEED_AVOID;
        out_turn_rate_mrad_s  <= lim_s;
      end else begin
        out_obstacle_ahead   <= 1'b0;
        out_turn_rate_mrad_s <= turn_w;
        if (turn_w > 13'(lwf_pkg::SlowTurnMrad) || turn_w < -13'(lwf_pkg::SlowTurnMrad))
          out_linear_speed_mm_s <= lwf_pkg::SPEED_SLOW;
        else
          out_linear_speed_mm_s <= lwf_pkg::SPEED_NORMAL;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/lidar_wall_follow_pid_top.sv -----
// Beam beat: accepted with no result; plain beams can follow back to back.
// A last beam with both side windows filled holds the input through the r and r1
// divisions, square root, numerator and distance divide (a zero norm ends it early).
// Tick beat: steps TA, TB and TC, then WAIT raises out_valid and reopens the input;
// an untaken result holds the tick's last step and the output register until taken.
// Reset (rst_n low, synchronous) loads register defaults and clears scan and PID state.
`default_nettype none
module lidar_wall_follow_pid_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_command,
  input  wire logic [15:0]        in_range_mm,
  input  wire logic               in_last_beam,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [4:0]              out_linear_speed_mm_s,
  output logic signed [12:0]      out_turn_rate_mrad_s,
  output logic                    out_obstacle_ahead,
  output logic signed [17:0]      out_wall_distance_mm
);

  lwf_pkg::lwf_cmd_t cmd;
  lwf_pkg::lwf_sts_t sts;

  lwf_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_command, .in_last_beam,
    .out_valid, .out_ready, .cmd, .sts
  );

  lwf_dp u_dp (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata, .in_range_mm, .cmd, .sts,
    .out_linear_speed_mm_s, .out_turn_rate_mrad_s, .out_obstacle_ahead,
    .out_wall_distance_mm
  );

endmodule
`default_nettype wire
